// ===== rtl/positional_stack_unit_macros.svh =====
// Assertion macros for the positional stack unit.
// Every macro expects a clock named clk and a reset named rst in scope.
`ifndef POSITIONAL_STACK_UNIT_MACROS_SVH
`define POSITIONAL_STACK_UNIT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define PSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define PSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/psu_pkg.sv =====
// Shared constants for the positional stack unit: sizes, field layout,
// op and status codes. No dependencies.
package psu_pkg;

  localparam int DEPTH  = 32;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  localparam int OP_W   = 3;
  localparam int POS_W  = 6;
  localparam int DATA_W = 32;
  localparam int STAT_W = 2;
  localparam int FILL_W = 6;
  localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

  localparam int IN_BITS  = OP_W + POS_W + DATA_W;
  localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
  localparam int OUT_BITS = DATA_W + STAT_W + FILL_W;
  localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

  localparam logic [OP_W-1:0] OP_PUSH    = 3'd0;
  localparam logic [OP_W-1:0] OP_INSERT  = 3'd1;
  localparam logic [OP_W-1:0] OP_POP     = 3'd2;
  localparam logic [OP_W-1:0] OP_EXTRACT = 3'd3;
  localparam logic [OP_W-1:0] OP_DUMP    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR   = 3'd5;

  localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
  localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL   = 2'd3;

endpackage

// ===== rtl/positional_stack_unit.sv =====
// Positional stack unit: bounded stack with insert/extract at a position.
// Depends on psu_pkg and positional_stack_unit_macros.svh.
// Sequence: push, clear and errors are answered from idle; pop reads the top slot, then answers;
//   extract reads the entry, then shifts the ones above down; insert shifts up, then writes.
// Flow: one request in flight; dump reads the next entry only once the last one has left.
// Reset: rst (sync, high) empties the stack; slot contents are not cleared.
`include "positional_stack_unit_macros.svh"

module positional_stack_unit (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_tvalid,
  output logic                      s_tready,
  // s_tdata from bit 0: op[2:0], position[8:3], value[40:9], zero pad
  input  logic [psu_pkg::IN_W-1:0]  s_tdata,
  output logic                      m_tvalid,
  input  logic                      m_tready,
  // m_tdata from bit 0: data_out[31:0], status[33:32], fill_count[39:34]
  output logic [psu_pkg::OUT_W-1:0] m_tdata,
  output logic                      m_tlast
);
  import psu_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_POP_RD, S_INS_SHIFT, S_INS_LAST, S_EXT_RD, S_EXT_SHIFT, S_DUMP
  } state_t;

  // Slot memory: one write port, one read port, registered read data.
  logic [DATA_W-1:0] mem [DEPTH];
  logic              we, re;
  logic [ADDR_W-1:0] waddr, raddr;
  logic [DATA_W-1:0] wdata, rdata;

  state_t            state, state_next;
  logic [CNT_W-1:0]  count, count_next;
  logic [ADDR_W-1:0] wptr, wptr_next;   // shift write target
  logic [ADDR_W-1:0] rptr, rptr_next;   // next dump read address
  logic              pend, pend_next;   // dump read data lands this cycle
  logic              last_pend, last_pend_next;
  logic [POS_W-1:0]  pos_q, pos_next;
  logic [DATA_W-1:0] val_q, val_next;
  logic [DATA_W-1:0] data_q, data_next; // extracted value held over the shift

  logic              out_load;
  logic [DATA_W-1:0] od;
  logic [STAT_W-1:0] ost;
  logic              olast;
  logic [DATA_W-1:0] out_data;
  logic [STAT_W-1:0] out_status;
  logic [FILL_W-1:0] out_fill;

  logic              out_free, in_fire;
  logic [OP_W-1:0]   in_op;
  logic [POS_W-1:0]  in_pos;
  logic [DATA_W-1:0] in_val;
  logic [CMP_W-1:0]  cnt_c, pos_c;

  assign out_free = !m_tvalid || m_tready;
  assign s_tready = (state == S_IDLE) && out_free;
  assign in_fire  = s_tvalid && s_tready;

  assign in_op  = s_tdata[OP_W-1:0];
  assign in_pos = s_tdata[OP_W +: POS_W];
  assign in_val = s_tdata[OP_W + POS_W +: DATA_W];
  assign cnt_c  = CMP_W'(count);
  assign pos_c  = CMP_W'(in_pos);

  assign m_tdata = OUT_W'({out_fill, out_status, out_data});

  always_comb begin
    state_next     = state;
    count_next     = count;
    wptr_next      = wptr;
    rptr_next      = rptr;
    pend_next      = pend;
    last_pend_next = last_pend;
    pos_next       = pos_q;
    val_next       = val_q;
    data_next      = data_q;
    we             = 1'b0;
    waddr          = wptr;
    wdata          = rdata;
    re             = 1'b0;
    raddr          = '0;
    out_load       = 1'b0;
    od             = '0;
    ost            = ST_OK;
    olast          = 1'b1;
    unique case (state)
      S_IDLE: begin
        if (in_fire) begin
          pos_next = in_pos;
          val_next = in_val;
          unique case (in_op)
            OP_PUSH: begin
              out_load = 1'b1;
              if (cnt_c >= CMP_W'(DEPTH)) begin
                ost = ST_FULL;
              end else begin
                we         = 1'b1;
                waddr      = ADDR_W'(count);
                wdata      = in_val;
                count_next = count + 1'b1;
              end
            end
            OP_INSERT: begin
              if (cnt_c >= CMP_W'(DEPTH)) begin
                out_load = 1'b1;
                ost      = ST_FULL;
              end else if (pos_c == '0 || pos_c > cnt_c + 1'b1) begin
                out_load = 1'b1;
                ost      = ST_BADPOS;
              end else if (pos_c == cnt_c + 1'b1) begin
                // insert on top: same as push
                out_load   = 1'b1;
                we         = 1'b1;
                waddr      = ADDR_W'(count);
                wdata      = in_val;
                count_next = count + 1'b1;
              end else begin
                re         = 1'b1;
                raddr      = ADDR_W'(count - 1'b1);
                wptr_next  = ADDR_W'(count);
                state_next = S_INS_SHIFT;
              end
            end
            OP_POP: begin
              if (count == '0) begin
                out_load = 1'b1;
                ost      = ST_EMPTY;
              end else begin
                re         = 1'b1;
                raddr      = ADDR_W'(count - 1'b1);
                count_next = count - 1'b1;
                state_next = S_POP_RD;
              end
            end
            OP_EXTRACT: begin
              if (count == '0) begin
                out_load = 1'b1;
                ost      = ST_EMPTY;
              end else if (pos_c == '0 || pos_c > cnt_c) begin
                out_load = 1'b1;
                ost      = ST_BADPOS;
              end else begin
                re         = 1'b1;
                raddr      = ADDR_W'(in_pos - 1'b1);
                state_next = S_EXT_RD;
              end
            end
            OP_DUMP: begin
              if (count == '0) begin
                out_load = 1'b1;
                ost      = ST_EMPTY;
              end else begin
                re             = 1'b1;
                raddr          = ADDR_W'(count - 1'b1);
                pend_next      = 1'b1;
                last_pend_next = (count == CNT_W'(1));
                rptr_next      = ADDR_W'(count - CNT_W'(2));
                state_next     = S_DUMP;
              end
            end
            OP_CLEAR: begin
              out_load   = 1'b1;
              count_next = '0;
            end
            default: begin
              out_load = 1'b1;
            end
          endcase
        end
      end
      S_POP_RD: begin
        out_load   = 1'b1;
        od         = rdata;
        state_next = S_IDLE;
      end
      S_INS_SHIFT: begin
        // move the entry read last cycle one place up
        we    = 1'b1;
        waddr = wptr;
        wdata = rdata;
        if (CMP_W'(wptr) == CMP_W'(pos_q)) begin
          state_next = S_INS_LAST;
        end else begin
          re        = 1'b1;
          raddr     = wptr - ADDR_W'(2);
          wptr_next = wptr - 1'b1;
        end
      end
      S_INS_LAST: begin
        we         = 1'b1;
        waddr      = ADDR_W'(pos_q - 1'b1);
        wdata      = val_q;
        count_next = count + 1'b1;
        out_load   = 1'b1;
        state_next = S_IDLE;
      end
      S_EXT_RD: begin
        data_next = rdata;
        if (CMP_W'(pos_q) == cnt_c) begin
          // top entry: nothing to move down
          count_next = count - 1'b1;
          out_load   = 1'b1;
          od         = rdata;
          state_next = S_IDLE;
        end else begin
          re         = 1'b1;
          raddr      = ADDR_W'(pos_q);
          wptr_next  = ADDR_W'(pos_q - 1'b1);
          state_next = S_EXT_SHIFT;
        end
      end
      S_EXT_SHIFT: begin
        we    = 1'b1;
        waddr = wptr;
        wdata = rdata;
        if (CMP_W'(wptr) + CMP_W'(2) == cnt_c) begin
          count_next = count - 1'b1;
          out_load   = 1'b1;
          od         = data_q;
          state_next = S_IDLE;
        end else begin
          re        = 1'b1;
          raddr     = wptr + ADDR_W'(2);
          wptr_next = wptr + 1'b1;
        end
      end
      S_DUMP: begin
        if (pend) begin
          // output register is empty here: reads are issued only when it frees
          out_load  = 1'b1;
          od        = rdata;
          olast     = last_pend;
          pend_next = 1'b0;
          if (last_pend) begin
            state_next = S_IDLE;
          end
        end else if (out_free) begin
          re             = 1'b1;
          raddr          = rptr;
          pend_next      = 1'b1;
          last_pend_next = (rptr == '0);
          rptr_next      = rptr - 1'b1;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      pend      <= 1'b0;
      last_pend <= 1'b0;
      m_tvalid  <= 1'b0;
    end else begin
      state     <= state_next;
      count     <= count_next;
      pend      <= pend_next;
      last_pend <= last_pend_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
    wptr   <= wptr_next;
    rptr   <= rptr_next;
    pos_q  <= pos_next;
    val_q  <= val_next;
    data_q <= data_next;
    if (out_load) begin
      out_data   <= od;
      out_status <= ost;
      out_fill   <= FILL_W'(count_next);
      m_tlast    <= olast;
    end
  end

  `PSU_ASSERT_IMP(a_count_bound, 1'b1, CMP_W'(count) <= CMP_W'(DEPTH),
    "stored count above depth")
  `PSU_ASSERT_IMP(a_no_overwrite, out_load, !m_tvalid || m_tready,
    "result register loaded while a result is still waiting")
  `PSU_ASSERT_IMP(a_port_clash, we && re, waddr != raddr,
    "shift reads and writes the same slot in one cycle")
  `PSU_ASSERT_NXT(a_dump_keeps_count, state == S_DUMP, $stable(count),
    "dump changed the stored count")

endmodule

// ===== test/positional_stack_unit_tb.sv =====
`timescale 1ns / 1ps
// Self-checking bench for positional_stack_unit: a stream of requests is driven and every
// result is checked against a behavioural stack kept alongside. Depends on psu_pkg and the unit.
module positional_stack_unit_tb;
  import psu_pkg::*;

  // Op codes the block does not define; they must still answer with one plain result.
  localparam logic [OP_W-1:0] OP_SPARE6 = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE7 = 3'd7;

  localparam int LIMIT_CYCLES = 500000;
  localparam int CALM_TAIL    = 30;   // requests at the end sent with no idling
  localparam int HOLD_AT      = 60;   // request count that starts the long receiver hold
  localparam int HOLD_CYCLES  = 200;
  localparam int SETTLE       = 80;   // longest dump plus margin

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [POS_W-1:0]  pos;
    logic [DATA_W-1:0] val;
    logic              drain_first;  // hold the request until every result is back
  } request_t;

  typedef struct packed {
    logic [DATA_W-1:0] data;
    logic [STAT_W-1:0] status;
    logic [FILL_W-1:0] fill;
    logic              last;
  } result_t;

  logic              clk;
  logic              rst = 1'b1;
  logic              s_tvalid = 1'b0;
  logic              s_tready;
  logic [IN_W-1:0]   s_tdata = '0;
  logic              m_tvalid;
  logic              m_tready = 1'b0;
  logic [OUT_W-1:0]  m_tdata;
  logic              m_tlast;

  request_t          pending_reqs[$];
  result_t           due_results[$];
  logic [DATA_W-1:0] shadow_slots[DEPTH];
  int                shadow_count = 0;
  int                plan_count = 0;
  int                accepted_reqs = 0;
  int                total_reqs = 0;
  int                mismatches = 0;
  int                cycle_count = 0;
  int                tx_gap = 0;
  int                rx_gap = 0;
  bit                took_request = 1'b0;
  logic              hold_rx = 1'b0;

  request_t          head;
  logic [IN_W-1:0]   word;
  result_t           seen;
  result_t           want;

  positional_stack_unit i_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
    mismatches++;
    $display("mismatch %s: got 0x%0h, expected 0x%0h (cycle %0d)",
             what, got, exp_val, cycle_count);
  endtask

  task automatic queue_result(logic [DATA_W-1:0] data, logic [STAT_W-1:0] status,
                              logic last);
    result_t r;
    r.data   = data;
    r.status = status;
    r.fill   = shadow_count[FILL_W-1:0];
    r.last   = last;
    due_results.push_back(r);
  endtask

  // Behavioural stack: slot i holds position i+1, the top sits at shadow_count-1.
  task automatic stack_apply(logic [OP_W-1:0] op, logic [POS_W-1:0] pos,
                             logic [DATA_W-1:0] val);
    int i;
    int p;
    logic [DATA_W-1:0] taken;
    p = int'(pos);
    case (op)
      OP_PUSH: begin
        if (shadow_count >= DEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
        end else begin
          shadow_slots[shadow_count] = val;
          shadow_count++;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_INSERT: begin
        if (shadow_count >= DEPTH) begin
          queue_result('0, ST_FULL, 1'b1);
        end else if (p == 0 || p > shadow_count + 1) begin
          queue_result('0, ST_BADPOS, 1'b1);
        end else begin
          for (i = shadow_count; i >= p; i--) shadow_slots[i] = shadow_slots[i-1];
          shadow_slots[p-1] = val;
          shadow_count++;
          queue_result('0, ST_OK, 1'b1);
        end
      end
      OP_POP: begin
        if (shadow_count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          shadow_count--;
          queue_result(shadow_slots[shadow_count], ST_OK, 1'b1);
        end
      end
      OP_EXTRACT: begin
        if (shadow_count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else if (p == 0 || p > shadow_count) begin
          queue_result('0, ST_BADPOS, 1'b1);
        end else begin
          taken = shadow_slots[p-1];
          for (i = p; i < shadow_count; i++) shadow_slots[i-1] = shadow_slots[i];
          shadow_count--;
          queue_result(taken, ST_OK, 1'b1);
        end
      end
      OP_DUMP: begin
        if (shadow_count == 0) begin
          queue_result('0, ST_EMPTY, 1'b1);
        end else begin
          for (i = 0; i < shadow_count; i++)
            queue_result(shadow_slots[shadow_count-1-i], ST_OK, i == shadow_count - 1);
        end
      end
      OP_CLEAR: begin
        shadow_count = 0;
        queue_result('0, ST_OK, 1'b1);
      end
      default: begin
        queue_result('0, ST_OK, 1'b1);
      end
    endcase
  endtask

  // Queues a request and tracks the count it will leave, so that later
  // requests can aim at real positions.
  task automatic plan_request(logic [OP_W-1:0] op, int pos, logic [DATA_W-1:0] val,
                              bit drain = 1'b0);
    request_t r;
    r.op          = op;
    r.pos         = pos[POS_W-1:0];
    r.val         = val;
    r.drain_first = drain;
    pending_reqs.push_back(r);
    case (op)
      OP_PUSH:    if (plan_count < DEPTH) plan_count++;
      OP_INSERT:  if (plan_count < DEPTH && r.pos != 0 && r.pos <= plan_count + 1)
                    plan_count++;
      OP_POP:     if (plan_count > 0) plan_count--;
      OP_EXTRACT: if (plan_count > 0 && r.pos != 0 && r.pos <= plan_count) plan_count--;
      OP_CLEAR:   plan_count = 0;
      default: ;
    endcase
  endtask

  function automatic logic [DATA_W-1:0] pick_value();
    case ($urandom_range(0, 15))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return 32'h0000_0000;
      3:       return 32'hffff_ffff;
      default: return $urandom;
    endcase
  endfunction

  // Mostly a position that exists, now and then any 6-bit value.
  function automatic int pick_pos(int hi);
    if (hi >= 1 && $urandom_range(0, 99) < 85) return $urandom_range(1, hi);
    return $urandom_range(0, (1 << POS_W) - 1);
  endfunction

  task automatic build_stimulus();
    int r;
    int k;
    bit drain;
    // Directed: empty-stack errors, bad positions, value extremes, shifts, every op.
    plan_request(OP_POP, 0, '0);
    plan_request(OP_EXTRACT, 5, '0);
    plan_request(OP_DUMP, 0, '0);
    plan_request(OP_INSERT, 0, 32'h1234_5678);
    plan_request(OP_INSERT, 2, 32'h1234_5678);
    plan_request(OP_INSERT, 1, 32'h7fff_ffff);
    plan_request(OP_PUSH, 0, 32'h8000_0000);
    plan_request(OP_PUSH, 63, 32'hffff_ffff);
    plan_request(OP_PUSH, 0, 32'h0000_0000);
    plan_request(OP_INSERT, 63, 32'haaaa_aaaa);
    plan_request(OP_INSERT, 5, 32'h0bad_cafe);  // one past the top acts as push
    plan_request(OP_INSERT, 1, $urandom);       // bottom: everything shifts up
    plan_request(OP_INSERT, 3, 32'h5555_5555);
    plan_request(OP_EXTRACT, 0, '0);
    plan_request(OP_EXTRACT, 63, '0);
    plan_request(OP_EXTRACT, 7, '0);            // the top entry
    plan_request(OP_EXTRACT, 1, '0);            // the bottom entry
    plan_request(OP_EXTRACT, 3, '0);
    plan_request(OP_DUMP, 0, '0);
    plan_request(OP_SPARE6, 0, '0);
    plan_request(OP_SPARE7, 63, 32'hffff_ffff);
    plan_request(OP_POP, 0, '0);
    plan_request(OP_CLEAR, 0, '0);
    plan_request(OP_POP, 0, '0);
    plan_request(OP_DUMP, 0, '0);

    // Random: fill to full, drain to empty, mixed traffic and raw noise.
    k = 270;
    drain = 1'b1;
    while (pending_reqs.size() < k) begin
      r = $urandom_range(0, 9);
      if (r <= 2) begin
        while (plan_count < DEPTH) begin
          if ($urandom_range(0, 1) == 0) plan_request(OP_PUSH, pick_pos(63), pick_value(), drain);
          else plan_request(OP_INSERT, $urandom_range(1, plan_count + 1), pick_value(), drain);
          drain = 1'b0;
        end
        plan_request(OP_PUSH, 0, pick_value());
        plan_request(OP_INSERT, $urandom_range(0, 63), pick_value());
        plan_request(OP_DUMP, 0, '0);
      end else if (r <= 4) begin
        while (plan_count > 0) begin
          if ($urandom_range(0, 1) == 0) plan_request(OP_POP, 0, '0, drain);
          else plan_request(OP_EXTRACT, pick_pos(plan_count), '0, drain);
          drain = 1'b0;
        end
        plan_request(OP_EXTRACT, $urandom_range(0, 63), '0);
        plan_request(OP_POP, 0, '0);
        plan_request(OP_DUMP, 0, '0);
      end else if (r <= 8) begin
        repeat (12) begin
          r = $urandom_range(0, 99);
          if (r < 22)      plan_request(OP_PUSH, 0, pick_value(), drain);
          else if (r < 44) plan_request(OP_INSERT, pick_pos(plan_count + 1), pick_value(), drain);
          else if (r < 60) plan_request(OP_POP, 0, '0, drain);
          else if (r < 78) plan_request(OP_EXTRACT, pick_pos(plan_count), '0, drain);
          else if (r < 88) plan_request(OP_DUMP, 0, '0, drain);
          else if (r < 92) plan_request(OP_CLEAR, 0, '0, drain);
          else plan_request(OP_W'($urandom_range(6, 7)), $urandom_range(0, 63), $urandom,
                            drain);
          drain = 1'b0;
        end
      end else begin
        repeat (6)
          plan_request(OP_W'($urandom_range(0, 7)), $urandom_range(0, 63), $urandom);
      end
      drain = ($urandom_range(0, 7) == 0);
    end
    total_reqs = pending_reqs.size();
  endtask

  // Request driver: changes on the falling edge, holds until accepted.
  always @(negedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else if (s_tvalid && !took_request) begin
      // waiting on s_tready
    end else if (tx_gap > 0) begin
      tx_gap--;
      s_tvalid <= 1'b0;
    end else if (pending_reqs.size() == 0) begin
      s_tvalid <= 1'b0;
    end else if (pending_reqs[0].drain_first && due_results.size() != 0) begin
      s_tvalid <= 1'b0;
    end else begin
      head = pending_reqs.pop_front();
      word = '0;
      word[0 +: OP_W]            = head.op;
      word[OP_W +: POS_W]        = head.pos;
      word[OP_W + POS_W +: DATA_W] = head.val;
      s_tdata  <= word;
      s_tvalid <= 1'b1;
      if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0)
        tx_gap = $urandom_range(1, 6);
    end
  end

  // Result receiver: random stall bursts, plus the long hold below.
  always @(negedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_rx) begin
      m_tready <= 1'b0;
    end else if (rx_gap > 0) begin
      rx_gap--;
      m_tready <= 1'b0;
    end else if (pending_reqs.size() >= CALM_TAIL && $urandom_range(0, 5) == 0) begin
      rx_gap = $urandom_range(0, 5);
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Long receiver hold while requests keep coming, so the input backs up.
  initial begin
    while (accepted_reqs < HOLD_AT) @(posedge clk);
    hold_rx <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_rx <= 1'b0;
  end

  // Monitor: predicts on each accepted request, checks each accepted result.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("[positional_stack_unit] ERROR");
      $finish;
    end
    took_request = !rst && s_tvalid && s_tready;
    if (!rst && m_tvalid && m_tready) begin
      seen.data   = m_tdata[0 +: DATA_W];
      seen.status = m_tdata[DATA_W +: STAT_W];
      seen.fill   = m_tdata[DATA_W + STAT_W +: FILL_W];
      seen.last   = m_tlast;
      if (due_results.size() == 0) begin
        report_mismatch("result with none outstanding", 64'(seen.data), '0);
      end else begin
        want = due_results.pop_front();
        if (seen.data !== want.data)
          report_mismatch("data_out", 64'(seen.data), 64'(want.data));
        if (seen.status !== want.status)
          report_mismatch("status", 64'(seen.status), 64'(want.status));
        if (seen.fill !== want.fill)
          report_mismatch("fill_count", 64'(seen.fill), 64'(want.fill));
        if (seen.last !== want.last)
          report_mismatch("tlast", 64'(seen.last), 64'(want.last));
      end
    end
    if (took_request) begin
      accepted_reqs++;
      stack_apply(s_tdata[0 +: OP_W], s_tdata[OP_W +: POS_W],
                  s_tdata[OP_W + POS_W +: DATA_W]);
    end
  end

  initial begin
    build_stimulus();
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    while (accepted_reqs < total_reqs) @(posedge clk);
    while (due_results.size() != 0) @(posedge clk);
    // Anything that shows up now is unexpected and gets flagged by the monitor.
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && due_results.size() == 0) begin
      $display("[positional_stack_unit] OK");
    end else begin
      $display("[positional_stack_unit] ERROR");
    end
    $finish;
  end

endmodule
